### rtl/bounded_list_with_delete_min_macros.svh
// Assertion macros shared by the bounded list RTL.
`ifndef BOUNDED_LIST_WITH_DELETE_MIN_MACROS_SVH
`define BOUNDED_LIST_WITH_DELETE_MIN_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication, disabled while reset is held.
`define BLWDM_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("blwdm: same-cycle check failed");
// Next-cycle implication, disabled while reset is held.
`define BLWDM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("blwdm: next-cycle check failed");
`else
`define BLWDM_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define BLWDM_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

### rtl/blwdm_pkg.sv
// Package: request and status codes, sequencer states and result type.
package blwdm_pkg;

  // Request codes
  localparam logic [2:0] REQ_INS_FRONT = 3'd0;
  localparam logic [2:0] REQ_INS_BACK  = 3'd1;
  localparam logic [2:0] REQ_DEL_POS   = 3'd2;
  localparam logic [2:0] REQ_DEL_MIN   = 3'd3;
  localparam logic [2:0] REQ_DUMP      = 3'd4;

  // Status codes
  localparam logic [1:0] STAT_OK     = 2'd0;
  localparam logic [1:0] STAT_FULL   = 2'd1;
  localparam logic [1:0] STAT_EMPTY  = 2'd2;
  localparam logic [1:0] STAT_BADPOS = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_WR,
    S_DEL_FETCH,
    S_DEL_GET,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_MIN_RD,
    S_MIN_CMP,
    S_DUMP_RD,
    S_DUMP_OUT,
    S_RESP
  } state_t;

  typedef struct packed {
    logic signed [31:0] item;
    logic [1:0]         status;
    logic               last;
  } res_t;

endpackage

### rtl/blwdm_store.sv
// Entry storage: one write port, one read port with registered read data.
module blwdm_store #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [31:0]   wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [31:0]   rd_data
);

  logic [31:0] mem_r [DEPTH];
  logic [31:0] rd_data_r;

  // Write one entry, read one entry per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### rtl/blwdm_ctrl.sv
// Sequencer: decodes requests and walks the store one entry at a time.
module blwdm_ctrl #(
  parameter int CAPACITY = 16,
  parameter int AW       = 4,
  parameter int LW       = 5
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [2:0]          in_req_type,
  input  logic signed [31:0]  in_value,
  input  logic [7:0]          in_position,
  output logic                res_valid,
  input  logic                res_ready,
  output blwdm_pkg::res_t     res,
  output logic [LW-1:0]       len,
  output logic                mem_wr_en,
  output logic [AW-1:0]       mem_wr_addr,
  output logic [31:0]         mem_wr_data,
  output logic                mem_rd_en,
  output logic [AW-1:0]       mem_rd_addr,
  input  logic [31:0]         mem_rd_data
);

  blwdm_pkg::state_t  state_r, state_nxt;
  logic [LW-1:0]      len_r, len_nxt;
  logic [AW-1:0]      idx_r, idx_nxt;
  logic [AW-1:0]      best_r, best_nxt;
  logic signed [31:0] val_r, val_nxt;
  logic [1:0]         stat_r, stat_nxt;

  logic               full;
  logic               empty;
  logic               idx_is_tail;
  logic               take;
  logic signed [31:0] rd_sval;

  assign full        = (len_r == LW'(CAPACITY));
  assign empty       = (len_r == '0);
  assign idx_is_tail = ((LW'(idx_r) + LW'(1)) == len_r);
  assign rd_sval     = $signed(mem_rd_data);
  // Minimum-scan compare: keep the first smallest value seen in the scan
  assign take        = (idx_r == '0) || (rd_sval < val_r);

  assign in_stall = (state_r != blwdm_pkg::S_IDLE);
  assign len      = len_r;

  // Hold state and length
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= blwdm_pkg::S_IDLE;
      len_r   <= '0;
    end else begin
      state_r <= state_nxt;
      len_r   <= len_nxt;
    end
  end

  // Hold working registers
  always_ff @(posedge clk) begin
    idx_r  <= idx_nxt;
    best_r <= best_nxt;
    val_r  <= val_nxt;
    stat_r <= stat_nxt;
  end

  // Advance the sequencer and drive the store
  always_comb begin
    state_nxt   = state_r;
    len_nxt     = len_r;
    idx_nxt     = idx_r;
    best_nxt    = best_r;
    val_nxt     = val_r;
    stat_nxt    = stat_r;
    mem_wr_en   = 1'b0;
    mem_wr_addr = idx_r;
    mem_wr_data = val_r;
    mem_rd_en   = 1'b0;
    mem_rd_addr = idx_r;
    res_valid   = 1'b0;
    res.item    = val_r;
    res.status  = stat_r;
    res.last    = 1'b1;

    case (state_r)
      blwdm_pkg::S_IDLE: begin
        if (in_valid) begin
          stat_nxt = blwdm_pkg::STAT_OK;
          case (in_req_type)
            blwdm_pkg::REQ_INS_FRONT: begin
              if (full) begin
                stat_nxt  = blwdm_pkg::STAT_FULL;
                val_nxt   = '0;
                state_nxt = blwdm_pkg::S_RESP;
              end else begin
                val_nxt   = in_value;
                idx_nxt   = AW'(len_r);
                state_nxt = blwdm_pkg::S_INS_RD;
              end
            end
            blwdm_pkg::REQ_INS_BACK: begin
              val_nxt   = '0;
              state_nxt = blwdm_pkg::S_RESP;
              if (full) begin
                stat_nxt = blwdm_pkg::STAT_FULL;
              end else begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = AW'(len_r);
                mem_wr_data = in_value;
                len_nxt     = len_r + LW'(1);
              end
            end
            blwdm_pkg::REQ_DEL_POS: begin
              val_nxt = '0;
              if (empty) begin
                stat_nxt  = blwdm_pkg::STAT_EMPTY;
                state_nxt = blwdm_pkg::S_RESP;
              end else if (in_position == 8'd0 ||
                           {1'b0, in_position} > 9'(len_r)) begin
                stat_nxt  = blwdm_pkg::STAT_BADPOS;
                state_nxt = blwdm_pkg::S_RESP;
              end else begin
                idx_nxt   = AW'(in_position - 8'd1);
                state_nxt = blwdm_pkg::S_DEL_FETCH;
              end
            end
            blwdm_pkg::REQ_DEL_MIN: begin
              if (empty) begin
                val_nxt   = '0;
                stat_nxt  = blwdm_pkg::STAT_EMPTY;
                state_nxt = blwdm_pkg::S_RESP;
              end else begin
                idx_nxt   = '0;
                best_nxt  = '0;
                state_nxt = blwdm_pkg::S_MIN_RD;
              end
            end
            blwdm_pkg::REQ_DUMP: begin
              if (empty) begin
                val_nxt   = '0;
                stat_nxt  = blwdm_pkg::STAT_EMPTY;
                state_nxt = blwdm_pkg::S_RESP;
              end else begin
                idx_nxt   = '0;
                state_nxt = blwdm_pkg::S_DUMP_RD;
              end
            end
            default: begin
              // drop unused request codes
              state_nxt = blwdm_pkg::S_IDLE;
            end
          endcase
        end
      end

      // Insert at front: move entries up from the tail, then write the head
      blwdm_pkg::S_INS_RD: begin
        if (idx_r == '0) begin
          mem_wr_en   = 1'b1;
          mem_wr_addr = '0;
          mem_wr_data = val_r;
          len_nxt     = len_r + LW'(1);
          val_nxt     = '0;
          state_nxt   = blwdm_pkg::S_RESP;
        end else begin
          mem_rd_en   = 1'b1;
          mem_rd_addr = idx_r - AW'(1);
          state_nxt   = blwdm_pkg::S_INS_WR;
        end
      end
      blwdm_pkg::S_INS_WR: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = idx_r;
        mem_wr_data = mem_rd_data;
        idx_nxt     = idx_r - AW'(1);
        state_nxt   = blwdm_pkg::S_INS_RD;
      end

      // Delete at position: capture the entry, then close the gap
      blwdm_pkg::S_DEL_FETCH: begin
        mem_rd_en = 1'b1;
        state_nxt = blwdm_pkg::S_DEL_GET;
      end
      blwdm_pkg::S_DEL_GET: begin
        val_nxt   = rd_sval;
        state_nxt = blwdm_pkg::S_SHIFT_RD;
      end

      // Close the gap: move entries down one place toward the front
      blwdm_pkg::S_SHIFT_RD: begin
        if (idx_is_tail) begin
          len_nxt   = len_r - LW'(1);
          state_nxt = blwdm_pkg::S_RESP;
        end else begin
          mem_rd_en   = 1'b1;
          mem_rd_addr = idx_r + AW'(1);
          state_nxt   = blwdm_pkg::S_SHIFT_WR;
        end
      end
      blwdm_pkg::S_SHIFT_WR: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = idx_r;
        mem_wr_data = mem_rd_data;
        idx_nxt     = idx_r + AW'(1);
        state_nxt   = blwdm_pkg::S_SHIFT_RD;
      end

      // Minimum scan over every stored entry
      blwdm_pkg::S_MIN_RD: begin
        mem_rd_en = 1'b1;
        state_nxt = blwdm_pkg::S_MIN_CMP;
      end
      blwdm_pkg::S_MIN_CMP: begin
        if (take) begin
          val_nxt  = rd_sval;
          best_nxt = idx_r;
        end
        if (idx_is_tail) begin
          idx_nxt   = take ? idx_r : best_r;
          state_nxt = blwdm_pkg::S_SHIFT_RD;
        end else begin
          idx_nxt   = idx_r + AW'(1);
          state_nxt = blwdm_pkg::S_MIN_RD;
        end
      end

      // Dump: one transaction per entry, front to back
      blwdm_pkg::S_DUMP_RD: begin
        mem_rd_en = 1'b1;
        state_nxt = blwdm_pkg::S_DUMP_OUT;
      end
      blwdm_pkg::S_DUMP_OUT: begin
        res_valid  = 1'b1;
        res.item   = rd_sval;
        res.status = blwdm_pkg::STAT_OK;
        res.last   = idx_is_tail;
        if (res_ready) begin
          if (idx_is_tail) begin
            state_nxt = blwdm_pkg::S_IDLE;
          end else begin
            idx_nxt   = idx_r + AW'(1);
            state_nxt = blwdm_pkg::S_DUMP_RD;
          end
        end
      end

      // Single-result reply
      blwdm_pkg::S_RESP: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = blwdm_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = blwdm_pkg::S_IDLE;
      end
    endcase
  end

endmodule

### rtl/bounded_list_with_delete_min.sv
// Top level: bounded ordered list with delete-minimum.
//
//   channel  direction  handshake           payload
//   in_      input      in_valid/in_stall   req_type[3], value[32] s, position[8]
//   out_     output     out_valid/out_stall item[32] s, status[2], last
//
// One request at a time; a sequencer walks the entry store through its single
// read port and single write port, one entry moved or visited at a time.
// Insert front moves every entry up; delete at position moves those behind it
// down; delete minimum scans every entry, then closes the gap behind it.
// Synchronous reset empties the list at once; the store is not cleared.
// A stalled result holds the sequencer; one result register lets it finish
// the next step while the previous transaction waits.
`include "bounded_list_with_delete_min_macros.svh"

module bounded_list_with_delete_min #(
  parameter int CAPACITY = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_req_type,
  input  logic signed [31:0] in_value,
  input  logic [7:0]         in_position,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_item,
  output logic [1:0]         out_status,
  output logic               out_last
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int LW = $clog2(CAPACITY + 1);

  blwdm_pkg::res_t res;
  logic            res_valid;
  logic            res_ready;
  logic            res_fire;
  logic [LW-1:0]   len;

  logic            mem_wr_en;
  logic [AW-1:0]   mem_wr_addr;
  logic [31:0]     mem_wr_data;
  logic            mem_rd_en;
  logic [AW-1:0]   mem_rd_addr;
  logic [31:0]     mem_rd_data;

  logic               out_valid_r;
  logic signed [31:0] out_item_r;
  logic [1:0]         out_status_r;
  logic               out_last_r;

  blwdm_ctrl #(
    .CAPACITY (CAPACITY),
    .AW       (AW),
    .LW       (LW)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_req_type (in_req_type),
    .in_value    (in_value),
    .in_position (in_position),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res),
    .len         (len),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data),
    .mem_rd_en   (mem_rd_en),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data)
  );

  blwdm_store #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  assign res_ready = !out_valid_r || !out_stall;
  assign res_fire  = res_valid && res_ready;

  // Load the result register, drop it once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_fire) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_fire) begin
      out_item_r   <= res.item;
      out_status_r <= res.status;
      out_last_r   <= res.last;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_item   = out_item_r;
  assign out_status = out_status_r;
  assign out_last   = out_last_r;

  `BLWDM_ASSERT_IMPLIES(a_len_bound, clk, rst_n, 1'b1, len <= LW'(CAPACITY))
  `BLWDM_ASSERT_IMPLIES(a_full_only_at_cap, clk, rst_n,
    res_fire && res.status == blwdm_pkg::STAT_FULL, len == LW'(CAPACITY))
  `BLWDM_ASSERT_IMPLIES(a_empty_only_at_zero, clk, rst_n,
    res_fire && res.status == blwdm_pkg::STAT_EMPTY, len == '0)
  `BLWDM_ASSERT_NEXT(a_idle_after_last, clk, rst_n, res_fire && res.last, !in_stall)

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the bounded list with delete-minimum.
module tb;

  localparam int CAPACITY      = 16;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 80;
  localparam int REPORT_MAX    = 10;

  // Request codes the block ignores
  localparam logic [2:0] REQ_SPARE_LO = 3'd5;
  localparam logic [2:0] REQ_SPARE_HI = 3'd7;

  localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] VAL_MAX = 32'sh7FFF_FFFF;

  logic               clk         = 1'b0;
  logic               rst_n       = 1'b0;
  logic               in_valid    = 1'b0;
  logic [2:0]         in_req_type = blwdm_pkg::REQ_INS_FRONT;
  logic signed [31:0] in_value    = '0;
  logic [7:0]         in_position = '0;
  logic               out_stall   = 1'b0;
  logic               in_stall;
  logic               out_valid;
  logic signed [31:0] out_item;
  logic [1:0]         out_status;
  logic               out_last;

  // Shadow copy of the list and the results it predicts
  logic signed [31:0] shadow_list [CAPACITY];
  int                 shadow_len = 0;
  blwdm_pkg::res_t    pending_results [$];

  int   fail_count  = 0;
  int   cycle_count = 0;
  logic gaps_on     = 1'b1;
  logic stalls_on   = 1'b1;
  logic hold_req    = 1'b0;

  bounded_list_with_delete_min #(
    .CAPACITY(CAPACITY)
  ) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_req_type(in_req_type),
    .in_value   (in_value),
    .in_position(in_position),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_item   (out_item),
    .out_status (out_status),
    .out_last   (out_last)
  );

  always #5 clk = ~clk;

  function automatic void note_failure(string msg);
    fail_count++;
    if (fail_count <= REPORT_MAX) $display("[%0t] %s", $time, msg);
  endfunction

  function automatic void expect_result(logic signed [31:0] item, logic [1:0] status,
                                        logic last);
    blwdm_pkg::res_t r;
    r.item   = item;
    r.status = status;
    r.last   = last;
    pending_results.push_back(r);
  endfunction

  // Remove one entry from the shadow list and close the gap
  function automatic logic signed [31:0] take_entry(int idx);
    logic signed [31:0] v;
    v = shadow_list[idx];
    for (int i = idx; i + 1 < shadow_len; i++) shadow_list[i] = shadow_list[i + 1];
    shadow_len--;
    return v;
  endfunction

  // Update the shadow list for one accepted request and queue its results
  function automatic void apply_request(logic [2:0] req, logic signed [31:0] val,
                                        logic [7:0] pos);
    int best;
    case (req)
      blwdm_pkg::REQ_INS_FRONT, blwdm_pkg::REQ_INS_BACK: begin
        if (shadow_len >= CAPACITY) begin
          expect_result('0, blwdm_pkg::STAT_FULL, 1'b1);
        end else begin
          if (req == blwdm_pkg::REQ_INS_FRONT) begin
            for (int i = shadow_len; i > 0; i--) shadow_list[i] = shadow_list[i - 1];
            shadow_list[0] = val;
          end else begin
            shadow_list[shadow_len] = val;
          end
          shadow_len++;
          expect_result('0, blwdm_pkg::STAT_OK, 1'b1);
        end
      end
      blwdm_pkg::REQ_DEL_POS: begin
        if (shadow_len == 0)
          expect_result('0, blwdm_pkg::STAT_EMPTY, 1'b1);
        else if (pos == 0 || int'(pos) > shadow_len)
          expect_result('0, blwdm_pkg::STAT_BADPOS, 1'b1);
        else
          expect_result(take_entry(int'(pos) - 1), blwdm_pkg::STAT_OK, 1'b1);
      end
      blwdm_pkg::REQ_DEL_MIN: begin
        if (shadow_len == 0) begin
          expect_result('0, blwdm_pkg::STAT_EMPTY, 1'b1);
        end else begin
          // first occurrence of the smallest value wins
          best = 0;
          for (int i = 1; i < shadow_len; i++)
            if (shadow_list[i] < shadow_list[best]) best = i;
          expect_result(take_entry(best), blwdm_pkg::STAT_OK, 1'b1);
        end
      end
      blwdm_pkg::REQ_DUMP: begin
        if (shadow_len == 0) expect_result('0, blwdm_pkg::STAT_EMPTY, 1'b1);
        else
          for (int i = 0; i < shadow_len; i++)
            expect_result(shadow_list[i], blwdm_pkg::STAT_OK, i == shadow_len - 1);
      end
      default: ;
    endcase
  endfunction

  function automatic void check_result(logic signed [31:0] item, logic [1:0] status,
                                       logic last);
    blwdm_pkg::res_t want;
    if (pending_results.size() == 0) begin
      note_failure($sformatf("unexpected result: item=%0d status=%0d last=%0d",
                             item, status, last));
      return;
    end
    want = pending_results.pop_front();
    if (item !== want.item || status !== want.status || last !== want.last)
      note_failure($sformatf(
        "result mismatch: expected item=%0d status=%0d last=%0d, got item=%0d status=%0d last=%0d",
        want.item, want.status, want.last, item, status, last));
  endfunction

  // Predict on each accepted request, check each accepted result
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) apply_request(in_req_type, in_value, in_position);
    if (rst_n && out_valid && !out_stall) check_result(out_item, out_status, out_last);
  end

  // Stall results in short random bursts, or hold off for a long stretch on request
  always begin : result_stall_gen
    int burst;
    @(posedge clk);
    if (hold_req) begin
      out_stall <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      hold_req = 1'b0;
      out_stall <= 1'b0;
    end else if (stalls_on && $urandom_range(0, 3) == 0) begin
      burst = $urandom_range(1, 4);
      out_stall <= 1'b1;
      repeat (burst) @(posedge clk);
      out_stall <= 1'b0;
    end
  end

  // End the run if it hangs
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL");
    $finish;
  end

  // Offer one request and hold it until accepted; valid stays high on return
  task automatic send_req(logic [2:0] req, logic signed [31:0] val, logic [7:0] pos);
    int gap;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 4);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_req_type <= req;
    in_value    <= val;
    in_position <= pos;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Drop valid and wait until every predicted result has come back
  task automatic wait_drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  function automatic logic [2:0] pick_req(int ins_pct);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < ins_pct) return roll[0] ? blwdm_pkg::REQ_INS_FRONT : blwdm_pkg::REQ_INS_BACK;
    if (roll < 92) return roll[0] ? blwdm_pkg::REQ_DEL_POS : blwdm_pkg::REQ_DEL_MIN;
    if (roll < 98) return blwdm_pkg::REQ_DUMP;
    return 3'($urandom_range(REQ_SPARE_LO, REQ_SPARE_HI));
  endfunction

  // Mix extremes, small values that repeat, and full-range values
  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 5))
      0:       return VAL_MIN;
      1:       return VAL_MAX;
      2, 3:    return int'($urandom_range(0, 8)) - 4;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [7:0] pick_position();
    if ($urandom_range(0, 7) == 0) return 8'($urandom_range(0, 255));
    return 8'($urandom_range(0, CAPACITY + 1));
  endfunction

  // Send random requests; ignored codes do not count toward the total
  task automatic send_random(int count, int ins_pct);
    logic [2:0] req;
    int sent;
    sent = 0;
    while (sent < count) begin
      req = pick_req(ins_pct);
      send_req(req, pick_value(), pick_position());
      if (req < REQ_SPARE_LO) sent++;
    end
  endtask

  // Every removal and dump on an empty list, plus an ignored code
  task automatic test_empty_list();
    send_req(blwdm_pkg::REQ_DUMP, '0, '0);
    send_req(blwdm_pkg::REQ_DEL_MIN, '0, '0);
    send_req(blwdm_pkg::REQ_DEL_POS, '0, 8'd1);
    send_req(REQ_SPARE_HI, VAL_MAX, 8'hFF);
    wait_drain();
  endtask

  // Fill to capacity from both ends, overflow both ends, dump a full list
  task automatic test_fill_and_overflow();
    logic signed [31:0] fill_vals [CAPACITY] = '{
      VAL_MAX, VAL_MIN, -1, 0, VAL_MIN, 1, 32'sh5555_5555, 32'shAAAA_AAAA,
      7, -7, 100, -100, 32'sh0F0F_0F0F, 32'shF0F0_F0F0, 2, -2};
    for (int i = 0; i < CAPACITY; i++)
      send_req(i[0] ? blwdm_pkg::REQ_INS_FRONT : blwdm_pkg::REQ_INS_BACK, fill_vals[i], '0);
    send_req(blwdm_pkg::REQ_INS_FRONT, 32'sd11, '0);
    send_req(blwdm_pkg::REQ_INS_BACK, 32'sd12, '0);
    send_req(blwdm_pkg::REQ_DUMP, '0, '0);
    wait_drain();
  endtask

  // Bad positions, delete at both ends, delete-minimum with a repeated minimum
  task automatic test_delete_cases();
    send_req(blwdm_pkg::REQ_DEL_POS, '0, 8'd0);
    send_req(blwdm_pkg::REQ_DEL_POS, '0, 8'd255);
    send_req(blwdm_pkg::REQ_DEL_POS, '0, 8'(CAPACITY));
    send_req(blwdm_pkg::REQ_DEL_MIN, '0, '0);
    send_req(blwdm_pkg::REQ_DEL_POS, '0, 8'd1);
    wait_drain();
  endtask

  // Random traffic, alternating between filling and draining phases
  task automatic test_random_mix();
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
    send_random(18, 80);
    send_random(18, 25);
    send_random(18, 70);
    send_random(18, 20);
    wait_drain();
  endtask

  // Hold off results for a long stretch while requests keep coming
  task automatic test_result_backpressure();
    gaps_on  = 1'b0;
    hold_req = 1'b1;
    send_random(15, 60);
    gaps_on = 1'b1;
    wait_drain();
  endtask

  // Back-to-back traffic with no idling on either side
  task automatic test_no_idle();
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    send_random(20, 50);
    wait_drain();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_list();
    test_fill_and_overflow();
    test_delete_cases();
    test_random_mix();
    test_result_backpressure();
    test_no_idle();
    // let any stray result show up before judging
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_results.size() != 0)
      note_failure($sformatf("%0d expected results never arrived", pending_results.size()));
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
